>>> design/urla_pkg.sv
// Package for the UART receive line assembler.
// Holds byte constants, register indexes and the cell control struct.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package urla_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [BYTE_W-1:0] PRINT_LOW  = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HIGH = 8'h7E;
   localparam logic [BYTE_W-1:0] TAB_BYTE   = 8'h09;
   localparam logic [BYTE_W-1:0] LF_BYTE    = 8'h0A;

   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_ASCII = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_EOL_CHAR     = 2'd1;

   // Control broadcast to every cell of the line chain.
   typedef struct packed {
      logic append;   // load the arriving byte into the first empty cell
      logic shift;    // move every cell one place towards the head
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> design/urla_req_if.sv
// Input channel of the line assembler: one received byte per word.
// Depends on urla_pkg for the byte width.
`default_nettype none

interface urla_req_if;
   logic                          valid;
   logic                          ready;
   logic [urla_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/urla_rsp_if.sv
// Result channel of the line assembler: one line byte and its last flag per word.
// Depends on urla_pkg for the byte width.
`default_nettype none

interface urla_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [urla_pkg::BYTE_W-1:0]   line_byte;
   logic                          line_last;

   modport source (output valid, output line_byte, output line_last, input ready);
   modport sink   (input valid, input line_byte, input line_last, output ready);
endinterface

`default_nettype wire

>>> design/urla_cell.sv
// One cell of the line chain: holds one buffered byte and an occupied flag.
// Depends on urla_pkg for the byte width and the cell control struct.
`default_nettype none

module urla_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire urla_pkg::cell_ctrl_type       ctrl,
   input  wire logic [urla_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic                          left_occ,
   input  wire logic [urla_pkg::BYTE_W-1:0]   right_byte,
   input  wire logic                          right_occ,
   output logic [urla_pkg::BYTE_W-1:0]        byte_out,
   output logic                               occ_out
);

   logic [urla_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        occ_ff, occ_in;

   // A cell takes the new byte only when it is the first empty one, that is
   // when it is empty and everything towards the head is already filled.
   always_comb begin
      byte_in = byte_ff;
      occ_in  = occ_ff;
      if (ctrl.shift) begin
         byte_in = right_byte;
         occ_in  = right_occ;
      end else if (ctrl.append && !occ_ff && left_occ) begin
         byte_in = rx_byte;
         occ_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign byte_out = byte_ff;
   assign occ_out  = occ_ff;

endmodule

`default_nettype wire

>>> design/uart_rx_line_assembler_top.sv
// UART receive line assembler, top level.
// Depends on urla_pkg, urla_req_if, urla_rsp_if and urla_cell.
//
// Use: received bytes enter on the req channel, one per word. With ASCII
// filtering on, bytes outside the printable range are dropped unless they
// are a tab or the end-of-line byte. Kept bytes fill a chain of LINE_BYTES
// cells. An end-of-line byte, or a byte that fills the chain, starts the
// drain: the line leaves on the rsp channel one byte per word, oldest first,
// without the end-of-line byte, and line_last marks its final byte. An
// end-of-line byte on an empty buffer produces nothing.
// Timing: input words may follow back to back while a line collects. The word
// that ends a line starts the drain in the next cycle: the line leaves one
// word a cycle while rsp.ready is high, as each taken word shifts the whole
// chain one cell towards the head. Input is not accepted during the drain,
// so the collection and the drain of a line never overlap.
// If the receiver stalls, the head byte simply stays on the outputs.
// Configuration (filter_ascii, eol_char) must be written through the csr port
// only while the block is idle; the block does not enforce this. Reset empties
// the chain, enables filtering and sets the end-of-line byte to line feed.
`default_nettype none

module uart_rx_line_assembler_top #(
   parameter int LINE_BYTES = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   urla_req_if.sink                                 req,
   urla_rsp_if.source                               rsp,
   input  wire logic                                csr_wr_en,
   input  wire logic [urla_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [urla_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   typedef enum logic {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   state_type                   state_ff, state_in;
   logic                        filter_ff, filter_in;
   logic [urla_pkg::BYTE_W-1:0] eol_ff, eol_in;

   urla_pkg::cell_ctrl_type     ctrl;
   logic [urla_pkg::BYTE_W-1:0] cell_byte [LINE_BYTES];
   logic                        cell_occ  [LINE_BYTES];

   logic accept, kept, is_eol, go_drain, taken;

   // Configuration registers.
   always_comb begin
      filter_in = filter_ff;
      eol_in    = eol_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            urla_pkg::REG_FILTER_ASCII: filter_in = csr_wr_data[0];
            urla_pkg::REG_EOL_CHAR:     eol_in    = csr_wr_data;
            default: ;
         endcase
      end
   end

   assign accept = req.valid && req.ready;
   assign is_eol = (req.rx_byte == eol_ff);
   assign kept   = !filter_ff
                   || ((req.rx_byte >= urla_pkg::PRINT_LOW)
                       && (req.rx_byte <= urla_pkg::PRINT_HIGH))
                   || is_eol
                   || (req.rx_byte == urla_pkg::TAB_BYTE);

   // The end-of-line byte is never stored. A plain byte that lands in the
   // last cell fills the chain and also starts the drain.
   assign ctrl.append = accept && kept && !is_eol;
   assign ctrl.shift  = taken;
   assign go_drain    = accept && kept
                        && (is_eol ? cell_occ[0] : cell_occ[LINE_BYTES-2]);
   assign taken       = rsp.valid && rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: if (go_drain) state_in = ST_DRAIN;
         ST_DRAIN:   if (taken && rsp.line_last) state_in = ST_COLLECT;
         default:    state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_COLLECT;
         filter_ff <= 1'b1;
         eol_ff    <= urla_pkg::LF_BYTE;
      end else begin
         state_ff  <= state_in;
         filter_ff <= filter_in;
         eol_ff    <= eol_in;
      end
   end

   for (genvar i = 0; i < LINE_BYTES; i++) begin : g_cell
      logic                        left_occ;
      logic [urla_pkg::BYTE_W-1:0] right_byte;
      logic                        right_occ;

      if (i == 0) begin : g_head
         assign left_occ = 1'b1;
      end else begin : g_body
         assign left_occ = cell_occ[i-1];
      end

      if (i == LINE_BYTES - 1) begin : g_tail
         assign right_byte = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner
         assign right_byte = cell_byte[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      urla_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .rx_byte    (req.rx_byte),
         .left_occ   (left_occ),
         .right_byte (right_byte),
         .right_occ  (right_occ),
         .byte_out   (cell_byte[i]),
         .occ_out    (cell_occ[i])
      );
   end

   assign req.ready     = (state_ff == ST_COLLECT);
   assign rsp.valid     = (state_ff == ST_DRAIN) && cell_occ[0];
   assign rsp.line_byte = cell_byte[0];
   assign rsp.line_last = !cell_occ[1];

endmodule

`default_nettype wire

>>> design/urla_checker.sv
// Port-level checker for the UART receive line assembler, bound to the top level.
// Depends on uart_rx_line_assembler_top and its channel interfaces.
`default_nettype none

module urla_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_ready,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [urla_pkg::BYTE_W-1:0]   line_byte,
   input  wire logic                          line_last
);

   // Input and output are never open together: a line drains before the next word.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req ready while a line word is offered");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("line word offered straight after reset");

   a_line_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !line_last) |=> rsp_valid)
      else $error("line ended without a last word");

   a_back_to_collect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && line_last) |=> (req_ready && !rsp_valid))
      else $error("not ready for input after the last word of a line");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(line_byte) && $stable(line_last)))
      else $error("stalled line word changed");

endmodule

bind uart_rx_line_assembler_top urla_checker u_urla_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .line_byte (rsp.line_byte),
   .line_last (rsp.line_last)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the UART receive line assembler.
// Needs urla_pkg, urla_req_if, urla_rsp_if and the design top; expects each emitted word
// from its own copy of the line store or a directed row, and checks it against the result channel.
`timescale 1ns / 1ps

module tb_top;

   localparam int LINE_BYTES  = 32;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 24;

   // Indexes past the register list; writes to them must be ignored.
   localparam logic [urla_pkg::CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [urla_pkg::CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   typedef logic [urla_pkg::BYTE_W-1:0] octet_type;

   typedef struct packed {
      octet_type data;
      logic      last;
   } line_word_type;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef enum logic [1:0] {
      SHAPE_SHORT, SHAPE_FULL, SHAPE_EOL_LAST, SHAPE_NOISE
   } line_shape_type;

   typedef struct packed {
      row_kind_type                     kind;
      logic [urla_pkg::CSR_INDEX_W-1:0] idx;
      octet_type                        val;
      logic                             typed;     // expectation written in the row
      logic                             one_word;  // typed row emits exactly one word
      octet_type                        exp_byte;
      logic                             exp_last;
   } dir_row_type;

   localparam int N_DIR = 29;
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h41, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h0A, 1'b1, 1'b1, 8'h41, 1'b1},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h0A, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h20, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h7E, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h1F, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h7F, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h09, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h0A, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  urla_pkg::REG_FILTER_ASCII, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h0A, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  urla_pkg::REG_EOL_CHAR,     8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h78, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  urla_pkg::REG_EOL_CHAR,     8'h78, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h78, 1'b1, 1'b1, 8'h78, 1'b1},
      '{ROW_CSR,  REG_SPARE_A,                8'h55, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  REG_SPARE_B,                8'hAA, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h78, 1'b1, 1'b1, 8'h01, 1'b1},
      '{ROW_CSR,  urla_pkg::REG_FILTER_ASCII, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,  urla_pkg::REG_EOL_CHAR,     8'h41, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h41, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h09, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_BYTE, urla_pkg::REG_FILTER_ASCII, 8'h41, 1'b1, 1'b1, 8'h09, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                             csr_wr_en;
   logic [urla_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [urla_pkg::CSR_DATA_W-1:0]  csr_wr_data;

   urla_req_if req_if ();
   urla_rsp_if rsp_if ();

   uart_rx_line_assembler_top #(.LINE_BYTES(LINE_BYTES)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Predictor state: our own copy of the registers and the line store.
   logic      cfg_filter;
   octet_type cfg_eol;
   octet_type asm_store [LINE_BYTES];
   int        asm_fill;

   line_word_type pending_words [$];
   int            err_cnt      = 0;
   int            quiet_cycles = 0;
   int            items_sent   = 0;
   int            src_idle_pct = 32;
   int            snk_idle_pct = 83;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got, want);
      err_cnt++;
   endtask

   // Works out the words that one received byte causes, if any.
   function automatic void assemble_line(input octet_type b, ref line_word_type words[$]);
      logic kept;
      logic is_eol;
      int   len;
      kept = !cfg_filter || (b >= urla_pkg::PRINT_LOW && b <= urla_pkg::PRINT_HIGH)
             || b == cfg_eol || b == urla_pkg::TAB_BYTE;
      if (!kept) return;
      if (asm_fill >= LINE_BYTES) asm_fill = 0;
      asm_store[asm_fill] = b;
      asm_fill++;
      is_eol = (b == cfg_eol);
      if (!is_eol && asm_fill < LINE_BYTES) return;
      len = is_eol ? asm_fill - 1 : asm_fill;
      asm_fill = 0;
      for (int k = 0; k < len; k++) begin
         words.push_back('{data: asm_store[k], last: (k + 1 == len)});
      end
   endfunction

   // Called and returning at a falling edge, with nothing yet driven in that step.
   task automatic send_byte(input octet_type b, input logic typed, input logic one_word,
                            input line_word_type typed_word);
      line_word_type words [$];
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      assemble_line(b, words);
      if (typed) begin
         if (one_word) pending_words.push_back(typed_word);
      end else begin
         foreach (words[k]) pending_words.push_back(words[k]);
      end
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_words.size() != 0);
   endtask

   // A byte that causes no word may still be in flight, so keep waiting after the words have drained.
   task automatic wait_idle();
      hold_until_drained();
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [urla_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [urla_pkg::CSR_DATA_W-1:0] val);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      if (idx == urla_pkg::REG_FILTER_ASCII) cfg_filter = val[0];
      else if (idx == urla_pkg::REG_EOL_CHAR) cfg_eol = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_line(input line_shape_type shape);
      int        n;
      int        roll;
      octet_type b;
      unique case (shape)
         SHAPE_SHORT:    n = $urandom_range(0, 8);
         SHAPE_FULL:     n = LINE_BYTES;
         SHAPE_EOL_LAST: n = LINE_BYTES - 1;
         default:        n = $urandom_range(1, 4);
      endcase
      for (int k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         // Long lines use printable bytes other than the terminator so every byte is kept and none ends the line early.
         if (shape == SHAPE_FULL || shape == SHAPE_EOL_LAST || (cfg_filter && roll < 80)) begin
            b = octet_type'($urandom_range(urla_pkg::PRINT_LOW, urla_pkg::PRINT_HIGH));
            if (b == cfg_eol) begin
               b = (cfg_eol == urla_pkg::PRINT_LOW) ? urla_pkg::PRINT_HIGH
                                                    : urla_pkg::PRINT_LOW;
            end
         end else if (cfg_filter && roll < 88) begin
            b = urla_pkg::TAB_BYTE;
         end else begin
            b = octet_type'($urandom_range(0, 255));
         end
         send_byte(b, 1'b0, 1'b0, '0);
      end
      if (shape == SHAPE_SHORT || shape == SHAPE_EOL_LAST) send_byte(cfg_eol, 1'b0, 1'b0, '0);
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
   end

   always @(posedge clock) begin
      line_word_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected word", rsp_if.line_byte, 0);
            end else begin
               want = pending_words.pop_front();
               if (rsp_if.line_byte !== want.data)
                  report_mismatch("line_byte", rsp_if.line_byte, want.data);
               if (rsp_if.line_last !== want.last)
                  report_mismatch("line_last", rsp_if.line_last, want.last);
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   initial begin
      int             start;
      int             roll;
      logic           paused;
      line_shape_type shape;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_index      = '0;
      csr_wr_data    = '0;
      cfg_filter     = 1'b1;
      cfg_eol        = urla_pkg::LF_BYTE;
      asm_fill       = 0;
      paused         = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIR_ROWS[r]) begin
         if (DIR_ROWS[r].kind == ROW_CSR) begin
            write_csr(DIR_ROWS[r].idx, DIR_ROWS[r].val);
         end else begin
            send_byte(DIR_ROWS[r].val, DIR_ROWS[r].typed, DIR_ROWS[r].one_word,
                      '{data: DIR_ROWS[r].exp_byte, last: DIR_ROWS[r].exp_last});
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         unique case (phase)
            0: begin
               src_idle_pct = 32;
               snk_idle_pct = 83;
               write_csr(urla_pkg::REG_FILTER_ASCII, 8'h01);
               write_csr(urla_pkg::REG_EOL_CHAR, urla_pkg::LF_BYTE);
               shape = SHAPE_FULL;
            end
            1: begin
               src_idle_pct = 83;
               snk_idle_pct = 32;
               write_csr(urla_pkg::REG_FILTER_ASCII, 8'h00);
               write_csr(urla_pkg::REG_EOL_CHAR, 8'h00);
               shape = SHAPE_EOL_LAST;
            end
            default: begin
               src_idle_pct = 0;
               snk_idle_pct = 0;
               write_csr(urla_pkg::REG_FILTER_ASCII,
                         urla_pkg::CSR_DATA_W'($urandom_range(0, 1)));
               write_csr(urla_pkg::REG_EOL_CHAR,
                         urla_pkg::CSR_DATA_W'($urandom_range(0, 255)));
               shape = SHAPE_SHORT;
            end
         endcase
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (phase == 2 && !paused && items_sent - start >= PHASE_ITEMS / 2) begin
               hold_until_drained();
               paused = 1'b1;
            end
            send_line(shape);
            roll = $urandom_range(0, 99);
            if (roll < 70)      shape = SHAPE_SHORT;
            else if (roll < 78) shape = SHAPE_FULL;
            else if (roll < 84) shape = SHAPE_EOL_LAST;
            else                shape = SHAPE_NOISE;
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      if (err_cnt == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
